[hdl/qcf_pkg.sv]
`timescale 1ns / 1ps
package qcf_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    KIND_MOVE   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_SPLINE = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  // Result point codes
  typedef enum logic [1:0] {
    PK_MOVE = 2'd0,
    PK_LINE = 2'd1,
    PK_END  = 2'd2,
    PK_NONE = 2'd3
  } point_kind_e;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 8'd1;

  localparam logic [15:0] FACTOR_RST = 16'd614;
  localparam logic [15:0] TOL_RST    = 16'd7;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/qcf_if.sv]
`timescale 1ns / 1ps
interface qcf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] ctrl_x;
  logic signed [31:0] ctrl_y;

  modport source (output valid, kind, end_x, end_y, ctrl_x, ctrl_y, input ready);
  modport sink   (input valid, kind, end_x, end_y, ctrl_x, ctrl_y, output ready);
endinterface

interface qcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [1:0]         point_kind;
  logic               keep;
  logic               last;

  modport source (output valid, point_x, point_y, point_kind, keep, last, input ready);
  modport sink   (input valid, point_x, point_y, point_kind, keep, last, output ready);
endinterface

interface qcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [qcf_pkg::CFG_IDX_W-1:0]  index;
  logic [qcf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/quadratic_curve_flattener_unit.sv]
// Move, line and end give their single result in the cycle after the beat.
// Spline: each point waits on the bit-serial divider, once per axis; NUMW = 45 at default parameters.
// Throughput: one input beat at a time; input is taken only in idle with a free output.
// Reset (rst_ni, async, active low): idle, no point held, origin as previous point,
// factor 614 and tolerance 7.
`timescale 1ns / 1ps
module quadratic_curve_flattener_unit #(
  parameter int MAX_PARTS       = 63,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qcf_in_if.sink    in_i,
  qcf_out_if.source out_o,
  qcf_cfg_if.sink   cfg_i
);

  localparam int NW     = $clog2(MAX_PARTS + 1);  // part count / index width
  localparam int SQW    = 2 * NW;                 // squares of the part count
  localparam int NUMW   = 32 + SQW + 1;           // rounded numerator
  localparam int ACCW   = 68;                     // holds s * f * f exactly
  localparam int MAW    = 36;
  localparam int MBW    = 16;
  localparam int PRODW  = MAW + MBW + 1;
  localparam int TW     = 51;                     // s * f
  localparam int TSPLIT = 26;
  localparam int SHIFT  = 16 + COORD_FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SUM   = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_ACC   = 10'b0000001000,
    S_COUNT = 10'b0000010000,
    S_SETUP = 10'b0000100000,
    S_DST   = 10'b0001000000,
    S_DWAIT = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_e;

  // Multiply-accumulate steps of one pass
  localparam logic [1:0] OP_A = 2'd0;
  localparam logic [1:0] OP_B = 2'd1;
  localparam logic [1:0] OP_C = 2'd2;

  state_e state_q, state_d;

  // Configuration
  logic [15:0] factor_q, tol_q;

  // Path state
  logic signed [31:0] prev_x_q, prev_y_q;
  logic               have_q;

  // Command under work
  logic signed [31:0] e_x_q, e_y_q, c_x_q, c_y_q, sp_x_q, sp_y_q;
  logic [34:0]        s_q;
  logic [TW-1:0]      t_q;
  logic signed [ACCW-1:0]  acc_q;
  logic signed [PRODW-1:0] prod_q;
  logic [1:0]         op_q;
  logic               cy_q, pc_q;
  logic [NW-1:0]      k_q, n_q, i_q;
  logic [SQW-1:0]     ksq_q, den_q, sq_a_q, sq_c_q;
  logic signed [31:0] res_x_q, res_y_q;

  // Output register
  logic               out_v_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic [1:0]         out_k_q;
  logic               out_keep_q, out_last_q;

  logic slot_free, in_acc;
  assign slot_free = !out_v_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_acc = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Curvature sum |e - 2c + p| per axis
  logic signed [33:0] ax, ay;
  logic [33:0]        abx, aby;
  assign ax  = {{2{e_x_q[31]}}, e_x_q} - {c_x_q[31], c_x_q, 1'b0} + {{2{sp_x_q[31]}}, sp_x_q};
  assign ay  = {{2{e_y_q[31]}}, e_y_q} - {c_y_q[31], c_y_q, 1'b0} + {{2{sp_y_q[31]}}, sp_y_q};
  assign abx = ax[33] ? 34'(-ax) : 34'(ax);
  assign aby = ay[33] ? 34'(-ay) : 34'(ay);

  // Middle weight 2*i*(n-i)
  logic [SQW-1:0] sq_b;
  assign sq_b = den_q - sq_a_q - sq_c_q;

  // Shared multiplier operand select
  logic signed [MAW-1:0]   mul_a;
  logic [MBW-1:0]          mul_b;
  logic signed [PRODW-1:0] prod_d;
  always_comb begin
    mul_a = '0;
    mul_b = factor_q;
    if (pc_q) begin
      unique case (op_q)
        OP_A:    mul_a = {1'b0, s_q};
        OP_B:    mul_a = {10'b0, t_q[TSPLIT-1:0]};
        default: mul_a = {11'b0, t_q[TW-1:TSPLIT]};
      endcase
    end else begin
      unique case (op_q)
        OP_A: begin
          mul_a = cy_q ? {{4{e_y_q[31]}}, e_y_q} : {{4{e_x_q[31]}}, e_x_q};
          mul_b = MBW'(sq_a_q);
        end
        OP_B: begin
          mul_a = cy_q ? {{4{c_y_q[31]}}, c_y_q} : {{4{c_x_q[31]}}, c_x_q};
          mul_b = MBW'(sq_b);
        end
        default: begin
          mul_a = cy_q ? {{4{sp_y_q[31]}}, sp_y_q} : {{4{sp_x_q[31]}}, sp_x_q};
          mul_b = MBW'(sq_c_q);
        end
      endcase
    end
  end
  assign prod_d = mul_a * $signed({1'b0, mul_b});

  // Accumulate: the numerator starts from den/2 for round-half-up.
  logic signed [ACCW-1:0] prod_ext, addend, base, acc_d;
  assign prod_ext = {{(ACCW-PRODW){prod_q[PRODW-1]}}, prod_q};
  assign addend   = (pc_q && op_q == OP_C) ? (prod_ext <<< TSPLIT) : prod_ext;
  always_comb begin
    unique case (op_q)
      OP_A:    base = pc_q ? '0 : $signed(ACCW'(den_q >> 1));
      OP_B:    base = pc_q ? '0 : acc_q;
      default: base = acc_q;
    endcase
  end
  assign acc_d = base + addend;

  // Part count trial: k*k << (16+F) against s*f*f
  logic [ACCW-1:0] lhs;
  logic            k_fits;
  assign lhs    = ACCW'(ksq_q) << SHIFT;
  assign k_fits = lhs <= $unsigned(acc_q);

  // Divider
  logic               div_start;
  logic signed [31:0] div_quot;
  qcf_pkg::div_stat_t div_stat;
  assign div_start = (state_q == S_DST);

  qcf_div #(.NUMW(NUMW), .DW(SQW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q[NUMW-1:0]),
    .divisor_i  (den_q),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  // Result load path, shared by single points, spline points and the end marker
  logic               ld;
  logic signed [31:0] ld_x, ld_y;
  logic [1:0]         ld_k;
  logic               ld_end;
  always_comb begin
    ld     = 1'b0;
    ld_x   = res_x_q;
    ld_y   = res_y_q;
    ld_k   = qcf_pkg::PK_LINE;
    ld_end = 1'b0;
    if (in_acc) begin
      unique case (qcf_pkg::kind_e'(in_i.kind))
        qcf_pkg::KIND_MOVE: begin
          ld = 1'b1; ld_x = in_i.end_x; ld_y = in_i.end_y; ld_k = qcf_pkg::PK_MOVE;
        end
        qcf_pkg::KIND_LINE: begin
          ld = 1'b1; ld_x = in_i.end_x; ld_y = in_i.end_y; ld_k = qcf_pkg::PK_LINE;
        end
        qcf_pkg::KIND_END: begin
          ld = 1'b1; ld_x = '0; ld_y = '0; ld_k = qcf_pkg::PK_END; ld_end = 1'b1;
        end
        default: ld = 1'b0;
      endcase
    end else if (state_q == S_EMIT && slot_free) begin
      ld = 1'b1;
    end
  end

  // Duplicate test against the previous emitted point
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [33:0]        delta_sum;
  logic               keep_d;
  assign dx        = {ld_x[31], ld_x} - {prev_x_q[31], prev_x_q};
  assign dy        = {ld_y[31], ld_y} - {prev_y_q[31], prev_y_q};
  assign adx       = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady       = dy[32] ? 33'(-dy) : 33'(dy);
  assign delta_sum = {1'b0, adx} + {1'b0, ady};
  assign keep_d    = ld_end || !have_q || (delta_sum >= {18'b0, tol_q});

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && in_i.kind == qcf_pkg::KIND_SPLINE) state_d = S_SUM;
      S_SUM:   state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC: begin
        if (op_q != OP_C) state_d = S_MUL;
        else if (pc_q)    state_d = S_COUNT;
        else              state_d = S_DST;
      end
      S_COUNT: if (!k_fits || k_q == NW'(MAX_PARTS)) state_d = S_SETUP;
      S_SETUP: state_d = S_MUL;
      S_DST:   state_d = S_DWAIT;
      S_DWAIT: if (div_stat.done) state_d = cy_q ? S_EMIT : S_MUL;
      S_EMIT:  if (slot_free) state_d = (i_q == n_q) ? S_IDLE : S_MUL;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      factor_q <= qcf_pkg::FACTOR_RST;
      tol_q    <= qcf_pkg::TOL_RST;
      prev_x_q <= '0;
      prev_y_q <= '0;
      have_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == qcf_pkg::CFG_FACTOR) factor_q <= cfg_i.data[15:0];
        if (cfg_i.index == qcf_pkg::CFG_TOL)    tol_q    <= cfg_i.data[15:0];
      end
      if (ld) begin
        out_v_q  <= 1'b1;
        prev_x_q <= ld_x;
        prev_y_q <= ld_y;
        have_q   <= !ld_end;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_x_q    <= ld_x;
      out_y_q    <= ld_y;
      out_k_q    <= ld_k;
      out_keep_q <= keep_d;
      out_last_q <= in_acc || (i_q == n_q);
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          e_x_q  <= in_i.end_x;
          e_y_q  <= in_i.end_y;
          c_x_q  <= in_i.ctrl_x;
          c_y_q  <= in_i.ctrl_y;
          sp_x_q <= prev_x_q;
          sp_y_q <= prev_y_q;
        end
      end
      S_SUM: begin
        s_q  <= {1'b0, abx} + {1'b0, aby};
        pc_q <= 1'b1;
        op_q <= OP_A;
      end
      S_MUL: prod_q <= prod_d;
      S_ACC: begin
        acc_q <= acc_d;
        if (pc_q && op_q == OP_A) t_q <= prod_q[TW-1:0];
        if (op_q != OP_C) op_q <= op_q + 2'd1;
        // Prime the part count search; hold the count during point passes.
        if (pc_q) begin
          k_q   <= NW'(1);
          ksq_q <= SQW'(1);
          n_q   <= NW'(1);
          den_q <= SQW'(1);
        end
      end
      S_COUNT: begin
        if (k_fits) begin
          n_q   <= k_q;
          den_q <= ksq_q;
          k_q   <= k_q + NW'(1);
          ksq_q <= ksq_q + SQW'({k_q, 1'b1});
        end
      end
      S_SETUP: begin
        pc_q   <= 1'b0;
        op_q   <= OP_A;
        cy_q   <= 1'b0;
        i_q    <= '0;
        sq_a_q <= '0;
        sq_c_q <= den_q;
      end
      S_DST: op_q <= OP_A;
      S_DWAIT: begin
        if (div_stat.done) begin
          if (cy_q) res_y_q <= div_quot;
          else      res_x_q <= div_quot;
          cy_q <= 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free && i_q != n_q) begin
          // Advance the weights to the next sample.
          sq_a_q <= sq_a_q + SQW'({i_q, 1'b1});
          sq_c_q <= sq_c_q - SQW'({n_q - i_q, 1'b0}) + SQW'(1);
          i_q    <= i_q + NW'(1);
          cy_q   <= 1'b0;
          op_q   <= OP_A;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_v_q;
  assign out_o.point_x    = out_x_q;
  assign out_o.point_y    = out_y_q;
  assign out_o.point_kind = out_k_q;
  assign out_o.keep       = out_keep_q;
  assign out_o.last       = out_last_q;

`ifndef ASSERT_OFF
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_den_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETUP) |-> (n_q != '0 && den_q == SQW'(n_q) * SQW'(n_q)))
    else $error("part count and divisor disagree");

  a_first_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && i_q == '0) |-> (res_x_q == sp_x_q && res_y_q == sp_y_q))
    else $error("first curve point is not the start point");

  a_last_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && i_q == n_q) |-> (res_x_q == e_x_q && res_y_q == e_y_q))
    else $error("last curve point is not the target");
`endif

endmodule

[hdl/qcf_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider, floor of a signed dividend by a positive divisor.
module qcf_div #(
  parameter int NUMW = 45,
  parameter int DW   = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NUMW-1:0] dividend_i,
  input  logic [DW-1:0]          divisor_i,
  output logic signed [31:0]     quot_o,
  output qcf_pkg::div_stat_t     stat_o
);

  localparam int CW = $clog2(NUMW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CW-1:0]   cnt_q;
  logic [NUMW-1:0] m_q;
  logic [DW-1:0]   rem_q, d_q;

  logic [DW:0]     rem_sh;
  logic            fits;
  logic [DW:0]     rem_nx;
  logic [NUMW-1:0] q_up, q_res;

  assign rem_sh = {rem_q, m_q[NUMW-1]};
  assign fits   = rem_sh >= {1'b0, d_q};
  assign rem_nx = fits ? rem_sh - {1'b0, d_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[NUMW-1];
      m_q   <= dividend_i[NUMW-1] ? NUMW'(-dividend_i) : NUMW'(dividend_i);
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      m_q   <= {m_q[NUMW-2:0], fits};
      rem_q <= rem_nx[DW-1:0];
    end
  end

  // Negative dividends round toward minus infinity.
  assign q_up   = m_q + NUMW'(rem_q != '0);
  assign q_res  = neg_q ? (~q_up + NUMW'(1)) : m_q;
  assign quot_o = q_res[31:0];
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

[bench/quadratic_curve_flattener_unit_test.sv]
`timescale 1ns / 1ps
module quadratic_curve_flattener_unit_test;

  localparam int MAX_PARTS = 63;
  localparam int FRAC_BITS = 16;
  localparam longint RUN_LIMIT_NS = 64'd60_000_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [31:0]   x;
    logic signed [31:0]   y;
    qcf_pkg::point_kind_e pk;
    bit                   keep;
    bit                   last;
  } flat_point_t;

  // Scoreboard: tracks flattener state and queues the points each command should produce.
  class flat_scoreboard;
    flat_point_t pending_pts[$];
    int unsigned factor = qcf_pkg::FACTOR_RST;
    int unsigned tol    = qcf_pkg::TOL_RST;
    longint      last_x = 0;
    longint      last_y = 0;
    bit          have_pt = 0;
    int          errors = 0;
    int          checked = 0;

    function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint round_div(longint num, longint den);
      longint q;
      q = num + den / 2;
      if (q >= 0) return q / den;
      return -((-q + den - 1) / den);
    endfunction

    function int unsigned parts_for(longint ex, longint ey, longint cx, longint cy);
      longint unsigned s, f2, lhs;
      int unsigned n;
      n  = 0;
      s  = mag(ex - 2 * cx + last_x) + mag(ey - 2 * cy + last_y);
      f2 = longint'(factor) * longint'(factor);
      if (f2 == 0) return 1;
      if (s > 64'hFFFF_FFFF_FFFF_FFFF / f2) return MAX_PARTS;
      for (int k = 1; k <= MAX_PARTS; k++) begin
        lhs = (longint'(k) * longint'(k)) << (16 + FRAC_BITS);
        if (lhs <= s * f2) n = k;
        else break;
      end
      return (n == 0) ? 1 : n;
    endfunction

    function void push_point(longint x, longint y, qcf_pkg::point_kind_e pk, bit last);
      flat_point_t p;
      p.x = x[31:0];
      p.y = y[31:0];
      p.pk = pk;
      p.last = last;
      p.keep = 1;
      // Mark points that land within tolerance of the previous emitted point as not kept
      if (have_pt && (mag(x - last_x) + mag(y - last_y) < longint'(tol))) p.keep = 0;
      pending_pts.push_back(p);
      last_x = longint'(p.x);
      last_y = longint'(p.y);
      have_pt = 1;
    endfunction

    function void set_reg(logic [qcf_pkg::CFG_IDX_W-1:0] idx,
                          logic [qcf_pkg::CFG_DATA_W-1:0] data);
      if (idx == qcf_pkg::CFG_FACTOR) factor = data[15:0];
      else if (idx == qcf_pkg::CFG_TOL) tol = data[15:0];
    endfunction

    function void note_command(qcf_pkg::kind_e kind, logic signed [31:0] ex,
                               logic signed [31:0] ey,
                               logic signed [31:0] cx, logic signed [31:0] cy);
      int unsigned n;
      longint a, b, c, den, px, py;
      case (kind)
        qcf_pkg::KIND_END: begin
          flat_point_t p;
          p.x = 0; p.y = 0; p.pk = qcf_pkg::PK_END; p.keep = 1; p.last = 1;
          pending_pts.push_back(p);
          last_x = 0; last_y = 0; have_pt = 0;
        end
        qcf_pkg::KIND_MOVE: push_point(longint'(ex), longint'(ey), qcf_pkg::PK_MOVE, 1);
        qcf_pkg::KIND_LINE: push_point(longint'(ex), longint'(ey), qcf_pkg::PK_LINE, 1);
        default: begin
          px = last_x;
          py = last_y;
          n = parts_for(longint'(ex), longint'(ey), longint'(cx), longint'(cy));
          den = longint'(n) * longint'(n);
          for (int i = 0; i <= n; i++) begin
            a = longint'(i) * i;
            b = 2 * longint'(i) * (n - i);
            c = longint'(n - i) * (n - i);
            push_point(round_div(longint'(ex) * a + longint'(cx) * b + px * c, den),
                       round_div(longint'(ey) * a + longint'(cy) * b + py * c, den),
                       qcf_pkg::PK_LINE, i == n);
          end
        end
      endcase
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic [1:0] pk, logic keep, logic last);
      flat_point_t e;
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h kind=%0d keep=%b last=%b",
                 $time, x, y, pk, keep, last);
        errors++;
        return;
      end
      e = pending_pts.pop_front();
      checked++;
      if (x !== e.x) begin
        $display("%0t: point_x expected %h actual %h", $time, e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: point_y expected %h actual %h", $time, e.y, y);
        errors++;
      end
      if (pk !== e.pk) begin
        $display("%0t: point_kind expected %0d actual %0d", $time, e.pk, pk);
        errors++;
      end
      if (keep !== e.keep) begin
        $display("%0t: keep expected %b actual %b", $time, e.keep, keep);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  qcf_in_if  cmd_bus ();
  qcf_out_if pt_bus ();
  qcf_cfg_if cfg_bus ();

  quadratic_curve_flattener_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (pt_bus),
    .cfg_i  (cfg_bus)
  );

  flat_scoreboard sb;

  int hold_left  = 0;   // long receiver hold-off, counted down by the ready process
  int stall_left = 0;
  bit calm       = 0;   // suppress random idling on both sides
  int n_cmds     = 0;
  int n_splines  = 0;
  int n_cfg      = 0;

  // Track the path end seen by the stimulus so near-duplicate points can be aimed at it
  logic signed [31:0] cur_x = 0;
  logic signed [31:0] cur_y = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Receiver: drive ready at the falling edge; honor the long hold-off first
  initial begin
    pt_bus.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pt_bus.ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        pt_bus.ready <= 0;
      end else begin
        pt_bus.ready <= 1;
        if (!calm && $urandom_range(9) < 3) stall_left = gap_len();
      end
    end
  end

  // Check every accepted output beat against the oldest expected point
  always @(posedge clk_i) begin
    if (rst_ni && pt_bus.valid && pt_bus.ready)
      sb.check_point(pt_bus.point_x, pt_bus.point_y, pt_bus.point_kind,
                     pt_bus.keep, pt_bus.last);
  end

  // Offer one command; valid stays high into the next call when no gap follows
  task automatic send_cmd(qcf_pkg::kind_e kind, logic signed [31:0] ex,
                          logic signed [31:0] ey,
                          logic signed [31:0] cx, logic signed [31:0] cy);
    int gap;
    @(negedge clk_i);
    cmd_bus.valid  <= 1;
    cmd_bus.kind   <= kind;
    cmd_bus.end_x  <= ex;
    cmd_bus.end_y  <= ey;
    cmd_bus.ctrl_x <= cx;
    cmd_bus.ctrl_y <= cy;
    do @(posedge clk_i); while (!cmd_bus.ready);
    sb.note_command(kind, ex, ey, cx, cy);
    n_cmds++;
    if (kind == qcf_pkg::KIND_SPLINE) n_splines++;
    if (kind == qcf_pkg::KIND_END) begin
      cur_x = 0;
      cur_y = 0;
    end else begin
      cur_x = ex;
      cur_y = ey;
    end
    gap = (!calm && $urandom_range(9) < 4) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_bus.valid <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    cmd_bus.valid <= 0;
  endtask

  // Wait until every expected point is out, then let the block settle
  task automatic drain();
    drop_valid();
    while (sb.pending_pts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [qcf_pkg::CFG_IDX_W-1:0] idx,
                           logic [qcf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.set_reg(idx, data);
    n_cfg++;
    @(negedge clk_i);
    cfg_bus.valid <= 0;
  endtask

  // Coordinate near a base: full range, a near duplicate, or within +-2^(span-1)
  function automatic logic signed [31:0] pick_coord(logic signed [31:0] base, int span);
    int r;
    logic signed [31:0] d;
    r = $urandom_range(19);
    if (r == 0) return $urandom;
    if (r < 4) return base + $urandom_range(0, 40) - 20;
    d = $urandom;
    return base + (d >>> (32 - span));
  endfunction

  // Mostly well-formed paths: move, a run of lines and splines, end; some noise
  task automatic send_random(int count, int span);
    qcf_pkg::kind_e k;
    int r;
    logic signed [31:0] ex, ey;
    bit open;
    open = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (!open) k = (r < 85) ? qcf_pkg::KIND_MOVE : qcf_pkg::kind_e'($urandom_range(1, 3));
      else if (r < 35) k = qcf_pkg::KIND_LINE;
      else if (r < 80) k = qcf_pkg::KIND_SPLINE;
      else if (r < 90) k = qcf_pkg::KIND_END;
      else k = qcf_pkg::KIND_MOVE;
      open = (k != qcf_pkg::KIND_END);
      ex = pick_coord(cur_x, span);
      ey = pick_coord(cur_y, span);
      send_cmd(k, ex, ey, pick_coord(cur_x, span), pick_coord(cur_y, span));
    end
    send_cmd(qcf_pkg::KIND_END, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    sb = new();
    rst_ni         = 0;
    cmd_bus.valid  = 0;
    cmd_bus.kind   = qcf_pkg::KIND_MOVE;
    cmd_bus.end_x  = 0;
    cmd_bus.end_y  = 0;
    cmd_bus.ctrl_x = 0;
    cmd_bus.ctrl_y = 0;
    cfg_bus.valid  = 0;
    cfg_bus.index  = 0;
    cfg_bus.data   = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: reset config, spline from the origin without a move, extremes,
    // duplicates, collinear spline, end marker with junk fields
    calm = 1;
    send_cmd(qcf_pkg::KIND_SPLINE, 32'sh0004_0000, 32'sh0000_0000, 32'sh0002_0000,
             32'sh0003_0000);
    send_cmd(qcf_pkg::KIND_LINE, 32'sh0004_0000, 32'sh0000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000);
    send_cmd(qcf_pkg::KIND_LINE, 32'sh0004_0003, 32'sh0000_0003, 0, 0);
    send_cmd(qcf_pkg::KIND_END, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000);
    send_cmd(qcf_pkg::KIND_MOVE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
    send_cmd(qcf_pkg::KIND_LINE, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
    send_cmd(qcf_pkg::KIND_SPLINE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7FFF_FFFF);
    send_cmd(qcf_pkg::KIND_MOVE, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
    send_cmd(qcf_pkg::KIND_SPLINE, 32'sh0003_0000, 32'sh0003_0000, 32'sh0002_0000,
             32'sh0002_0000);
    send_cmd(qcf_pkg::KIND_MOVE, 32'sh0003_0002, 32'sh0003_0002, 0, 0);
    send_cmd(qcf_pkg::KIND_SPLINE, 32'shFFF0_0000, 32'sh0010_0000, 32'sh0100_0000,
             32'shFF00_0000);
    send_cmd(qcf_pkg::KIND_LINE, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh5555_5555,
             32'shAAAA_AAAA);
    send_cmd(qcf_pkg::KIND_END, 0, 0, 0, 0);
    send_cmd(qcf_pkg::KIND_END, 0, 0, 0, 0);
    send_cmd(qcf_pkg::KIND_LINE, 0, 0, 0, 0);
    send_cmd(qcf_pkg::KIND_SPLINE, 0, 0, 0, 0);
    send_cmd(qcf_pkg::KIND_END, 0, 0, 0, 0);
    drain();
    calm = 0;

    // Default registers
    send_random(110, 21);
    drain();

    // Zero factor and zero tolerance: every spline collapses to one part
    write_reg(qcf_pkg::CFG_FACTOR, 32'd0);
    write_reg(qcf_pkg::CFG_TOL, 32'd0);
    send_random(45, 24);
    drain();

    // Both registers at maximum; keep coordinates tight so splines stay short-ish
    write_reg(qcf_pkg::CFG_FACTOR, 32'd65535);
    write_reg(qcf_pkg::CFG_TOL, 32'd65535);
    send_random(12, 12);
    drain();

    // Upper data bits and an unknown index must be ignored
    write_reg(qcf_pkg::CFG_FACTOR, 32'hABCD_0100);
    write_reg(qcf_pkg::CFG_TOL, 32'h1234_012C);
    write_reg(8'd5, 32'h0000_0001);
    write_reg(8'hFF, 32'hFFFF_FFFF);

    // Hold the receiver off while commands keep coming, so the block backs up
    hold_left = 800;
    for (int n = 0; n < 25; n++)
      send_cmd(($urandom_range(1) != 0) ? qcf_pkg::KIND_LINE : qcf_pkg::KIND_MOVE,
               pick_coord(cur_x, 20), pick_coord(cur_y, 20), $urandom, $urandom);
    send_random(40, 20);
    // Pause the sender until the queue runs dry, then carry on
    drain();
    send_random(40, 20);
    drain();

    // Smallest nonzero settings
    write_reg(qcf_pkg::CFG_FACTOR, 32'd1);
    write_reg(qcf_pkg::CFG_TOL, 32'd1);
    send_random(45, 26);
    drain();

    repeat (200) @(posedge clk_i);
    $display("Covered %0d commands (%0d splines), %0d points checked, %0d register writes",
             n_cmds, n_splines, sb.checked, n_cfg);
    $display("Settings swept: reset, zero, maximum, masked upper bits, minimum; one long hold");
    if (sb.errors == 0 && sb.pending_pts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.pending_pts.size() != 0)
        $display("%0t: %0d expected points never arrived", $time, sb.pending_pts.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/qcf_pkg.sv
hdl/qcf_if.sv
hdl/qcf_div.sv
hdl/quadratic_curve_flattener_unit.sv
bench/quadratic_curve_flattener_unit_test.sv
